// ===== rtl/core/qcb_pkg.sv =====
// Shared types, constants and lookup tables for the quantizer coefficient builder.
// Used by the channel interfaces, every pipeline module and the port checker.
// No dependencies.
package qcb_pkg;

	localparam int FLAG_W   = 1;
	localparam int SCALE_W  = 16;
	localparam int BASE_W   = 8;
	localparam int SPAN_W   = 6;
	localparam int Q_W      = 13;
	localparam int MULT_W   = 16;
	localparam int SHIFT_W  = 4;

	// Interpolation datapath widths.
	localparam int WSUM_W   = 14;
	localparam int NUM_W    = 15;
	localparam int DIVR_W   = SPAN_W + 1;
	localparam int RECIP_W  = 16;
	localparam int IPROD_W  = NUM_W + RECIP_W;

	// Scaling datapath widths.
	localparam int SPROD_W   = SCALE_W + BASE_W;
	localparam int PCT_RECIP_W = 25;
	localparam int PCT_SHIFT = 31;
	localparam int PCT_MUL_W = SPROD_W + PCT_RECIP_W;
	localparam int QUOT_W    = PCT_MUL_W - PCT_SHIFT;

	// Reciprocal divider widths.
	localparam int LOG_W       = 4;
	localparam int REM_W       = Q_W + 1;
	localparam int DIV_STAGES  = 4;
	localparam int DIV_BITS    = MULT_W / DIV_STAGES;

	localparam logic [SPROD_W-1:0]     PERCENT     = SPROD_W'(100);
	localparam logic [PCT_RECIP_W-1:0] PCT_RECIP   = PCT_RECIP_W'(21474836);
	localparam logic [QUOT_W-1:0]      QUOT_SAT    = QUOT_W'(1024);
	localparam logic [Q_W-1:0]         Q_MAX       = Q_W'(4096);
	localparam logic [Q_W-1:0]         DC_MIN_INTRA = Q_W'(16);
	localparam logic [Q_W-1:0]         DC_MIN_INTER = Q_W'(32);
	localparam logic [Q_W-1:0]         AC_MIN_INTRA = Q_W'(8);
	localparam logic [Q_W-1:0]         AC_MIN_INTER = Q_W'(16);
	localparam logic [LOG_W-1:0]       NORM_MSB    = LOG_W'(Q_W - 1);
	localparam logic [Q_W-1:0]         NORM_ONE    = Q_W'(4096);
	localparam logic [REM_W-1:0]       DIV_REM_INIT = REM_W'(4096);
	localparam logic [MULT_W-1:0]      MULT_POW2   = MULT_W'(1);

	// floor(65536 / (2*s)) for a span s; the entry for a zero span is never used.
	localparam logic [RECIP_W-1:0] INTERP_RECIP [64] = '{
		16'd0,     16'd32768, 16'd16384, 16'd10922, 16'd8192, 16'd6553, 16'd5461, 16'd4681,
		16'd4096,  16'd3640,  16'd3276,  16'd2978,  16'd2730, 16'd2520, 16'd2340, 16'd2184,
		16'd2048,  16'd1927,  16'd1820,  16'd1724,  16'd1638, 16'd1560, 16'd1489, 16'd1424,
		16'd1365,  16'd1310,  16'd1260,  16'd1213,  16'd1170, 16'd1129, 16'd1092, 16'd1057,
		16'd1024,  16'd992,   16'd963,   16'd936,   16'd910,  16'd885,  16'd862,  16'd840,
		16'd819,   16'd799,   16'd780,   16'd762,   16'd744,  16'd728,  16'd712,  16'd697,
		16'd682,   16'd668,   16'd655,   16'd642,   16'd630,  16'd618,  16'd606,  16'd595,
		16'd585,   16'd574,   16'd564,   16'd555,   16'd546,  16'd537,  16'd528,  16'd520
	};

	typedef struct packed {
		logic                is_inter;
		logic                is_dc;
		logic [SCALE_W-1:0]  scale;
		logic [BASE_W-1:0]   base_start;
		logic [BASE_W-1:0]   base_end;
		logic [SPAN_W-1:0]   step_in_range;
		logic [SPAN_W-1:0]   range_span;
	} coef_req_t;

	typedef struct packed {
		logic                is_inter;
		logic                is_dc;
		logic [SCALE_W-1:0]  scale;
		logic [BASE_W-1:0]   base;
	} interp_res_t;

	typedef struct packed {
		logic [BASE_W-1:0]   base;
		logic [Q_W-1:0]      quantizer;
		logic [LOG_W-1:0]    log2q;
	} step_res_t;

	typedef struct packed {
		logic [Q_W-1:0]      quantizer;
		logic [BASE_W-1:0]   interpolated_base;
		logic [MULT_W-1:0]   recip_mult;
		logic [SHIFT_W-1:0]  recip_shift;
	} coef_res_t;

	function automatic logic [Q_W-1:0] min_step(input logic is_dc, input logic is_inter);
		logic [Q_W-1:0] lo;
		if (is_dc) begin
			lo = is_inter ? DC_MIN_INTER : DC_MIN_INTRA;
		end else begin
			lo = is_inter ? AC_MIN_INTER : AC_MIN_INTRA;
		end
		return lo;
	endfunction

endpackage

// ===== rtl/core/qcb_if.sv =====
// Valid/ready channel interfaces for coefficient requests and results.
// Depends on qcb_pkg for field widths.
interface qcb_coef_in_if;
	logic                         valid;
	logic                         ready;
	logic                         is_inter;
	logic                         is_dc;
	logic [qcb_pkg::SCALE_W-1:0]  scale;
	logic [qcb_pkg::BASE_W-1:0]   base_start;
	logic [qcb_pkg::BASE_W-1:0]   base_end;
	logic [qcb_pkg::SPAN_W-1:0]   step_in_range;
	logic [qcb_pkg::SPAN_W-1:0]   range_span;

	modport source (output valid, is_inter, is_dc, scale, base_start, base_end,
		step_in_range, range_span, input ready);
	modport sink (input valid, is_inter, is_dc, scale, base_start, base_end,
		step_in_range, range_span, output ready);
endinterface

interface qcb_coef_out_if;
	logic                               valid;
	logic                               ready;
	logic [qcb_pkg::Q_W-1:0]            quantizer;
	logic [qcb_pkg::BASE_W-1:0]         interpolated_base;
	logic signed [qcb_pkg::MULT_W-1:0]  recip_mult;
	logic [qcb_pkg::SHIFT_W-1:0]        recip_shift;

	modport source (output valid, quantizer, interpolated_base, recip_mult, recip_shift,
		input ready);
	modport sink (input valid, quantizer, interpolated_base, recip_mult, recip_shift,
		output ready);
endinterface

// ===== rtl/core/qcb_interp.sv =====
// Three-stage rounded interpolation of the base matrix value inside a range.
// Depends on qcb_pkg (types, reciprocal table).
module qcb_interp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  qcb_pkg::coef_req_t     in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output qcb_pkg::interp_res_t   out_data
);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic [qcb_pkg::SPAN_W-1:0]  r_sat;
	logic [qcb_pkg::WSUM_W-1:0]  wsum;

	logic [qcb_pkg::NUM_W-1:0]    num_s1, num_s2;
	logic [qcb_pkg::RECIP_W-1:0]  recip_s1;
	logic [qcb_pkg::DIVR_W-1:0]   div_s1, div_s2;
	logic                         zero_s1, zero_s2;
	logic [qcb_pkg::BASE_W-1:0]   a_s1, a_s2;
	logic                         inter_s1, inter_s2, inter_s3;
	logic                         dc_s1, dc_s2, dc_s3;
	logic [qcb_pkg::SCALE_W-1:0]  scale_s1, scale_s2, scale_s3;
	logic [qcb_pkg::IPROD_W-1:0]  prod_s2;
	logic [qcb_pkg::BASE_W-1:0]   base_s3;

	logic [qcb_pkg::BASE_W-1:0]   est;
	logic [qcb_pkg::NUM_W-1:0]    back, rem;
	logic [qcb_pkg::BASE_W-1:0]   base_c;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// An offset past the span is treated as the end of the range.
	always_comb begin
		r_sat = (in_data.step_in_range > in_data.range_span) ? in_data.range_span
			: in_data.step_in_range;
		wsum = qcb_pkg::WSUM_W'(in_data.range_span - r_sat) * qcb_pkg::WSUM_W'(in_data.base_start)
			+ qcb_pkg::WSUM_W'(r_sat) * qcb_pkg::WSUM_W'(in_data.base_end);
	end

	// The estimate from the truncated reciprocal is at most one low.
	always_comb begin
		est    = prod_s2[qcb_pkg::RECIP_W +: qcb_pkg::BASE_W];
		back   = qcb_pkg::NUM_W'(est) * qcb_pkg::NUM_W'(div_s2);
		rem    = num_s2 - back;
		base_c = (rem >= qcb_pkg::NUM_W'(div_s2)) ? est + 1'b1 : est;
		if (zero_s2) begin
			base_c = a_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			num_s1   <= {wsum, 1'b0} + qcb_pkg::NUM_W'(in_data.range_span);
			recip_s1 <= qcb_pkg::INTERP_RECIP[in_data.range_span];
			div_s1   <= {in_data.range_span, 1'b0};
			zero_s1  <= (in_data.range_span == '0);
			a_s1     <= in_data.base_start;
			inter_s1 <= in_data.is_inter;
			dc_s1    <= in_data.is_dc;
			scale_s1 <= in_data.scale;
		end
		if (en_s2) begin
			prod_s2  <= qcb_pkg::IPROD_W'(num_s1) * qcb_pkg::IPROD_W'(recip_s1);
			num_s2   <= num_s1;
			div_s2   <= div_s1;
			zero_s2  <= zero_s1;
			a_s2     <= a_s1;
			inter_s2 <= inter_s1;
			dc_s2    <= dc_s1;
			scale_s2 <= scale_s1;
		end
		if (en_s3) begin
			base_s3  <= base_c;
			inter_s3 <= inter_s2;
			dc_s3    <= dc_s2;
			scale_s3 <= scale_s2;
		end
	end

	assign out_valid         = v_s3;
	assign out_data.is_inter = inter_s3;
	assign out_data.is_dc    = dc_s3;
	assign out_data.scale    = scale_s3;
	assign out_data.base     = base_s3;

endmodule

// ===== rtl/core/qcb_scale.sv =====
// Four-stage quantizer step: scale times base, divide by 100, clamp, log2.
// Depends on qcb_pkg (types, constants, minimum-step function).
module qcb_scale (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  qcb_pkg::interp_res_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output qcb_pkg::step_res_t     out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic [qcb_pkg::SPROD_W-1:0]  prod_s1, prod_s2;
	logic [qcb_pkg::QUOT_W-1:0]   est_s2, quot_s3;
	logic [qcb_pkg::BASE_W-1:0]   base_s1, base_s2, base_s3, base_s4;
	logic [qcb_pkg::Q_W-1:0]      lo_s1, lo_s2, lo_s3;
	logic [qcb_pkg::Q_W-1:0]      q_s4;
	logic [qcb_pkg::LOG_W-1:0]    lg_s4;

	logic [qcb_pkg::PCT_MUL_W-1:0] pct_mul;
	logic [qcb_pkg::SPROD_W-1:0]   rem;
	logic [qcb_pkg::QUOT_W-1:0]    quot_c;
	logic [qcb_pkg::Q_W-1:0]       q_c;
	logic [qcb_pkg::LOG_W-1:0]     lg_c;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign pct_mul = qcb_pkg::PCT_MUL_W'(prod_s1) * qcb_pkg::PCT_MUL_W'(qcb_pkg::PCT_RECIP);

	// Reciprocal estimate of the division by 100 is exact or one low.
	always_comb begin
		rem    = prod_s2 - qcb_pkg::SPROD_W'(est_s2) * qcb_pkg::PERCENT;
		quot_c = (rem >= qcb_pkg::PERCENT) ? est_s2 + 1'b1 : est_s2;
	end

	always_comb begin
		if (quot_s3 >= qcb_pkg::QUOT_SAT) begin
			q_c = qcb_pkg::Q_MAX;
		end else begin
			q_c = {1'b0, quot_s3[9:0], 2'b00};
			if (q_c < lo_s3) begin
				q_c = lo_s3;
			end
		end
		lg_c = '0;
		for (int i = 0; i < qcb_pkg::Q_W; i++) begin
			if (q_c[i]) lg_c = qcb_pkg::LOG_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= qcb_pkg::SPROD_W'(in_data.scale) * qcb_pkg::SPROD_W'(in_data.base);
			base_s1 <= in_data.base;
			lo_s1   <= qcb_pkg::min_step(in_data.is_dc, in_data.is_inter);
		end
		if (en_s2) begin
			est_s2  <= pct_mul[qcb_pkg::PCT_SHIFT +: qcb_pkg::QUOT_W];
			prod_s2 <= prod_s1;
			base_s2 <= base_s1;
			lo_s2   <= lo_s1;
		end
		if (en_s3) begin
			quot_s3 <= quot_c;
			base_s3 <= base_s2;
			lo_s3   <= lo_s2;
		end
		if (en_s4) begin
			q_s4    <= q_c;
			lg_s4   <= lg_c;
			base_s4 <= base_s3;
		end
	end

	assign out_valid          = v_s4;
	assign out_data.base      = base_s4;
	assign out_data.quantizer = q_s4;
	assign out_data.log2q     = lg_s4;

endmodule

// ===== rtl/core/qcb_recip.sv =====
// Reciprocal multiplier and shift: normalisation stage followed by a
// pipelined restoring divider, four quotient bits per stage. Depends on qcb_pkg.
module qcb_recip (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  qcb_pkg::step_res_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output qcb_pkg::coef_res_t    out_data
);

	localparam int LAST = qcb_pkg::DIV_STAGES + 1;

	logic                          v_s   [1:LAST];
	logic                          en_s  [1:LAST];
	logic [qcb_pkg::REM_W-1:0]     rem_s [1:LAST];
	logic [qcb_pkg::MULT_W-1:0]    quo_s [1:LAST];
	logic [qcb_pkg::Q_W-1:0]       m_s   [1:LAST];
	logic                          pow2_s[1:LAST];
	logic [qcb_pkg::Q_W-1:0]       q_s   [1:LAST];
	logic [qcb_pkg::LOG_W-1:0]     lg_s  [1:LAST];
	logic [qcb_pkg::BASE_W-1:0]    base_s[1:LAST];

	logic [qcb_pkg::Q_W-1:0]       norm_c;

	// Radix-2 restoring steps; the numerator bits below the top are all zero.
	function automatic logic [qcb_pkg::REM_W+qcb_pkg::MULT_W-1:0] div_steps(
		input logic [qcb_pkg::REM_W-1:0]  rem_in,
		input logic [qcb_pkg::MULT_W-1:0] quo_in,
		input logic [qcb_pkg::Q_W-1:0]    den);
		logic [qcb_pkg::REM_W-1:0]  r;
		logic [qcb_pkg::MULT_W-1:0] qq;
		r  = rem_in;
		qq = quo_in;
		for (int i = 0; i < qcb_pkg::DIV_BITS; i++) begin
			r = {r[qcb_pkg::REM_W-2:0], 1'b0};
			if (r >= qcb_pkg::REM_W'(den)) begin
				r  = r - qcb_pkg::REM_W'(den);
				qq = {qq[qcb_pkg::MULT_W-2:0], 1'b1};
			end else begin
				qq = {qq[qcb_pkg::MULT_W-2:0], 1'b0};
			end
		end
		return {r, qq};
	endfunction

	// The quantizer scaled so its leading one sits in the top bit.
	assign norm_c = in_data.quantizer << (qcb_pkg::NORM_MSB - in_data.log2q);

	always_comb begin
		en_s[LAST] = !v_s[LAST] || out_ready;
		for (int k = LAST - 1; k >= 1; k--) begin
			en_s[k] = !v_s[k] || en_s[k+1];
		end
	end
	assign in_ready = en_s[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			if (en_s[1]) v_s[1] <= in_valid;
			for (int k = 2; k <= LAST; k++) begin
				if (en_s[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s[1]) begin
			m_s[1]    <= norm_c;
			pow2_s[1] <= (norm_c == qcb_pkg::NORM_ONE);
			rem_s[1]  <= qcb_pkg::DIV_REM_INIT;
			quo_s[1]  <= '0;
			q_s[1]    <= in_data.quantizer;
			lg_s[1]   <= in_data.log2q;
			base_s[1] <= in_data.base;
		end
	end

	for (genvar k = 2; k <= LAST; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en_s[k]) begin
				{rem_s[k], quo_s[k]} <= div_steps(rem_s[k-1], quo_s[k-1], m_s[k-1]);
				m_s[k]    <= m_s[k-1];
				pow2_s[k] <= pow2_s[k-1];
				q_s[k]    <= q_s[k-1];
				lg_s[k]   <= lg_s[k-1];
				base_s[k] <= base_s[k-1];
			end
		end
	end

	// A power-of-two quantizer gives a multiplier of 1, which is 65537 truncated to 16 bits.
	assign out_valid                  = v_s[LAST];
	assign out_data.quantizer         = q_s[LAST];
	assign out_data.interpolated_base = base_s[LAST];
	assign out_data.recip_mult        = pow2_s[LAST] ? qcb_pkg::MULT_POW2 : quo_s[LAST] + 1'b1;
	assign out_data.recip_shift       = lg_s[LAST] + 1'b1;

endmodule

// ===== rtl/core/quantizer_coefficient_builder.sv =====
// Top level of the quantizer coefficient builder: twelve-stage pipeline.
// Depends on qcb_pkg, qcb_if, qcb_interp, qcb_scale and qcb_recip.
//
//   Channel    Modport   Direction  Payload
//   coef_in    sink      input      is_inter, is_dc, scale, base_start, base_end,
//                                   step_in_range, range_span
//   coef_out   source    output     quantizer, interpolated_base, recip_mult, recip_shift
//
// One transaction is accepted per clock while coef_out does not stall; the stages are the
// interpolation (three), the scaling path (four), and the normalisation stage and the
// restoring divider (four stages) that together form the reciprocal.
// Reset clears only the stage valid bits; the pipeline is empty and ready after reset.
// Each stage moves on when it is empty or the stage after it moves, so bubbles close up
// and a stall on coef_out holds every loaded stage without loss or duplication.
module quantizer_coefficient_builder (
	input  logic             clk,
	input  logic             arst_n,
	qcb_coef_in_if.sink      coef_in,
	qcb_coef_out_if.source   coef_out
);

	qcb_pkg::coef_req_t    req;
	qcb_pkg::interp_res_t  interp_data;
	qcb_pkg::step_res_t    step_data;
	qcb_pkg::coef_res_t    res;

	logic interp_valid, interp_ready;
	logic step_valid, step_ready;

	// Gather the request fields into one word for the first section.
	assign req.is_inter      = coef_in.is_inter;
	assign req.is_dc         = coef_in.is_dc;
	assign req.scale         = coef_in.scale;
	assign req.base_start    = coef_in.base_start;
	assign req.base_end      = coef_in.base_end;
	assign req.step_in_range = coef_in.step_in_range;
	assign req.range_span    = coef_in.range_span;

	// Rounded interpolation between the two base-matrix entries.
	qcb_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (coef_in.valid),
		.in_ready  (coef_in.ready),
		.in_data   (req),
		.out_valid (interp_valid),
		.out_ready (interp_ready),
		.out_data  (interp_data)
	);

	// Scaling by the quality scale, division by 100, clamping and the log2 of the step.
	qcb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (interp_valid),
		.in_ready  (interp_ready),
		.in_data   (interp_data),
		.out_valid (step_valid),
		.out_ready (step_ready),
		.out_data  (step_data)
	);

	// Reciprocal multiplier for division-free quantisation; its last stage is the
	// output register seen on coef_out.
	qcb_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step_valid),
		.in_ready  (step_ready),
		.in_data   (step_data),
		.out_valid (coef_out.valid),
		.out_ready (coef_out.ready),
		.out_data  (res)
	);

	assign coef_out.quantizer         = res.quantizer;
	assign coef_out.interpolated_base = res.interpolated_base;
	assign coef_out.recip_mult        = $signed(res.recip_mult);
	assign coef_out.recip_shift       = res.recip_shift;

endmodule

// ===== rtl/core/qcb_checker.sv =====
// Port-level checks on the quantizer coefficient builder, and the bind that attaches them.
// Depends on qcb_pkg for field widths.
module qcb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [qcb_pkg::Q_W-1:0]     quantizer,
	input logic [qcb_pkg::BASE_W-1:0]  interpolated_base,
	input logic [qcb_pkg::MULT_W-1:0]  recip_mult,
	input logic [qcb_pkg::SHIFT_W-1:0] recip_shift
);

	// A stalled result must hold still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quantizer)
			&& $stable(interpolated_base) && $stable(recip_mult) && $stable(recip_shift))
		else $error("result changed while stalled");

	a_no_valid_in_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result offered during reset");

	a_q_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quantizer >= 13'd8 && quantizer <= 13'd4096)
		else $error("quantizer outside clamp range");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> recip_shift >= 4'd4 && recip_shift <= 4'd13)
		else $error("reciprocal shift out of range");

	// The shift is one more than the position of the quantizer's leading one.
	a_shift_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quantizer >> (recip_shift - 4'd1)) == 13'd1)
		else $error("reciprocal shift does not match quantizer");

endmodule

bind quantizer_coefficient_builder qcb_checker u_qcb_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (coef_out.valid),
	.out_ready         (coef_out.ready),
	.quantizer         (coef_out.quantizer),
	.interpolated_base (coef_out.interpolated_base),
	.recip_mult        (coef_out.recip_mult),
	.recip_shift       (coef_out.recip_shift)
);

// ===== sim/quantizer_coefficient_builder_test.sv =====
// Self-checking testbench for the quantizer coefficient builder.
// Depends on qcb_pkg, the channel interfaces in qcb_if and the quantizer_coefficient_builder RTL.
// Drives requests with random gaps, predicts every result and checks them in order.
module quantizer_coefficient_builder_test;
	timeunit 1ns;
	timeprecision 1ps;

	// The pipeline is twelve stages deep, so this many quiet cycles after the last
	// expected result is ample to catch a stray extra transaction.
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned RANDOM_ITEMS  = 1000;
	// Number of request transactions after which the receiver holds off for a while.
	localparam int unsigned HOLD_AFTER    = 400;
	localparam int unsigned HOLD_CYCLES   = 90;

	logic clk;
	logic arst_n;

	qcb_coef_in_if  coef_in_ch ();
	qcb_coef_out_if coef_out_ch ();

	quantizer_coefficient_builder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef_in (coef_in_ch),
		.coef_out(coef_out_ch)
	);

	// Requests waiting to be offered, and the results that accepted requests must produce.
	qcb_pkg::coef_req_t pending_requests[$];
	qcb_pkg::coef_res_t expected_coefs[$];

	int unsigned issued_requests   = 0;
	int unsigned accepted_requests = 0;
	int unsigned mismatch_count    = 0;
	int unsigned sender_gap        = 0;
	int unsigned receiver_gap      = 0;
	logic        request_taken     = 1'b0;
	logic        receiver_hold     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Independent model of one coefficient: rounded interpolation, percentage scaling,
	// clamping and the reciprocal for division-free quantisation.
	function automatic qcb_pkg::coef_res_t predict_coefficient(input qcb_pkg::coef_req_t req);
		qcb_pkg::coef_res_t res;
		logic [31:0] span;
		logic [31:0] offset;
		logic [31:0] base;
		logic [31:0] step;
		logic [31:0] floor_step;
		logic [31:0] divisor;
		logic [31:0] log2d;
		logic [31:0] mult;
		span   = 32'(req.range_span);
		offset = 32'(req.step_in_range);
		if (span == 0) begin
			base = 32'(req.base_start);
		end else begin
			// An offset past the end of the range sticks at the end entry.
			if (offset > span) begin
				offset = span;
			end
			base = ((2 * ((span - offset) * 32'(req.base_start) + offset * 32'(req.base_end))
				+ span) / (2 * span)) & 32'hFF;
		end
		step = ((32'(req.scale) * base) / 100) << 2;
		if (req.is_dc) begin
			floor_step = req.is_inter ? 32'(qcb_pkg::DC_MIN_INTER) : 32'(qcb_pkg::DC_MIN_INTRA);
		end else begin
			floor_step = req.is_inter ? 32'(qcb_pkg::AC_MIN_INTER) : 32'(qcb_pkg::AC_MIN_INTRA);
		end
		if (step < floor_step) begin
			step = floor_step;
		end
		if (step > 32'(qcb_pkg::Q_MAX)) begin
			step = 32'(qcb_pkg::Q_MAX);
		end
		divisor = step << 1;
		log2d   = 0;
		while ((divisor >> (log2d + 1)) != 0) begin
			log2d++;
		end
		mult = 1 + ((32'd1 << (16 + log2d)) / divisor);
		res.quantizer         = step[qcb_pkg::Q_W-1:0];
		res.interpolated_base = base[qcb_pkg::BASE_W-1:0];
		res.recip_mult        = mult[qcb_pkg::MULT_W-1:0];
		res.recip_shift       = log2d[qcb_pkg::SHIFT_W-1:0];
		return res;
	endfunction

	// Every fourth block of 128 requests runs with no idling on either side, and both
	// sides stay busy while the receiver is held off so that the pipeline truly fills.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (receiver_hold || ((accepted_requests / 128) % 4) == 2) begin
			return 0;
		end
		if (roll < 60) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_request(input logic inter, input logic dc, input logic [15:0] scale,
			input logic [7:0] a, input logic [7:0] b, input logic [5:0] r, input logic [5:0] s);
		qcb_pkg::coef_req_t req;
		req.is_inter      = inter;
		req.is_dc         = dc;
		req.scale         = scale;
		req.base_start    = a;
		req.base_end      = b;
		req.step_in_range = r;
		req.range_span    = s;
		pending_requests.push_back(req);
		issued_requests++;
	endtask

	// Holds the stimulus back until the pipeline has delivered everything it owes.
	task automatic wait_for_drain();
		while (accepted_requests != issued_requests || expected_coefs.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Request side: bookkeeping at the rising edge, where a transaction completes.
	always @(posedge clk) begin : accept_requests
		qcb_pkg::coef_req_t req;
		if (arst_n && coef_in_ch.valid && coef_in_ch.ready) begin
			req.is_inter      = coef_in_ch.is_inter;
			req.is_dc         = coef_in_ch.is_dc;
			req.scale         = coef_in_ch.scale;
			req.base_start    = coef_in_ch.base_start;
			req.base_end      = coef_in_ch.base_end;
			req.step_in_range = coef_in_ch.step_in_range;
			req.range_span    = coef_in_ch.range_span;
			expected_coefs.push_back(predict_coefficient(req));
			accepted_requests++;
			request_taken <= 1'b1;
		end else begin
			request_taken <= 1'b0;
		end
	end

	// Request side: the offer changes only at the falling edge. An offer that has not
	// been taken yet is held steady, as the handshake requires.
	always @(negedge clk) begin : drive_requests
		qcb_pkg::coef_req_t req;
		if (!arst_n) begin
			coef_in_ch.valid <= 1'b0;
		end else if (coef_in_ch.valid && !request_taken) begin
			// Still waiting for the block to take the current transaction.
		end else if (sender_gap != 0) begin
			coef_in_ch.valid <= 1'b0;
			sender_gap       <= sender_gap - 1;
		end else if (pending_requests.size() != 0) begin
			req = pending_requests.pop_front();
			coef_in_ch.valid         <= 1'b1;
			coef_in_ch.is_inter      <= req.is_inter;
			coef_in_ch.is_dc         <= req.is_dc;
			coef_in_ch.scale         <= req.scale;
			coef_in_ch.base_start    <= req.base_start;
			coef_in_ch.base_end      <= req.base_end;
			coef_in_ch.step_in_range <= req.step_in_range;
			coef_in_ch.range_span    <= req.range_span;
			sender_gap               <= pick_gap();
		end else begin
			coef_in_ch.valid <= 1'b0;
		end
	end

	task automatic check_field(input string field, input int expected, input int actual);
		if (expected != actual) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field,
				expected, actual);
			mismatch_count++;
		end
	endtask

	// Result side: every completed transaction is matched against the oldest prediction.
	always @(posedge clk) begin : check_results
		qcb_pkg::coef_res_t want;
		if (arst_n && coef_out_ch.valid && coef_out_ch.ready) begin
			if (expected_coefs.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got quantizer %0d",
					$time, coef_out_ch.quantizer);
				mismatch_count++;
			end else begin
				want = expected_coefs.pop_front();
				check_field("quantizer", int'(want.quantizer), int'(coef_out_ch.quantizer));
				check_field("interpolated_base", int'(want.interpolated_base),
					int'(coef_out_ch.interpolated_base));
				check_field("recip_mult", int'($signed(want.recip_mult)),
					int'($signed(coef_out_ch.recip_mult)));
				check_field("recip_shift", int'(want.recip_shift),
					int'(coef_out_ch.recip_shift));
			end
		end
	end

	// Result side: ready is lowered for random stretches, or for the long hold-off.
	always @(negedge clk) begin
		if (!arst_n || receiver_hold) begin
			coef_out_ch.ready <= 1'b0;
		end else if (receiver_gap != 0) begin
			coef_out_ch.ready <= 1'b0;
			receiver_gap      <= receiver_gap - 1;
		end else begin
			coef_out_ch.ready <= 1'b1;
			receiver_gap      <= pick_gap();
		end
	end

	// Long hold-off on the result side, counted here, while requests keep coming, so
	// that the pipeline fills completely and has to push back on its input.
	initial begin
		while (accepted_requests < HOLD_AFTER) begin
			@(posedge clk);
		end
		@(negedge clk);
		receiver_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		receiver_hold = 1'b0;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int unsigned   pick;
		int unsigned   span;
		int unsigned   offset;
		logic [15:0]   scale;
		// Every input is at a known level before the first clock edge.
		arst_n                   = 1'b0;
		coef_in_ch.valid         = 1'b0;
		coef_in_ch.is_inter      = 1'b0;
		coef_in_ch.is_dc         = 1'b0;
		coef_in_ch.scale         = '0;
		coef_in_ch.base_start    = '0;
		coef_in_ch.base_end      = '0;
		coef_in_ch.step_in_range = '0;
		coef_in_ch.range_span    = '0;
		coef_out_ch.ready        = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Zero scale and zero base land on each of the four minimum steps.
		queue_request(1'b0, 1'b0, 16'd0,     8'd0,   8'd0,   6'd0,  6'd1);
		queue_request(1'b1, 1'b0, 16'd0,     8'd90,  8'd90,  6'd0,  6'd1);
		queue_request(1'b0, 1'b1, 16'd500,   8'd0,   8'd0,   6'd3,  6'd7);
		queue_request(1'b1, 1'b1, 16'd0,     8'd200, 8'd100, 6'd2,  6'd5);
		// All fields at their top values; the step saturates at the upper clamp.
		queue_request(1'b1, 1'b1, 16'hFFFF,  8'hFF,  8'hFF,  6'h3F, 6'h3F);
		// A zero span keeps the start entry, whatever the offset.
		queue_request(1'b0, 1'b0, 16'd1000,  8'd200, 8'd7,   6'd5,  6'd0);
		queue_request(1'b1, 1'b0, 16'd300,   8'd17,  8'd250, 6'h3F, 6'd0);
		// Offsets at or beyond the span stick at the end entry.
		queue_request(1'b0, 1'b1, 16'd500,   8'd10,  8'd240, 6'd40, 6'd20);
		queue_request(1'b1, 1'b0, 16'd700,   8'd3,   8'd77,  6'h3F, 6'd62);
		queue_request(1'b0, 1'b0, 16'd100,   8'd3,   8'd200, 6'd33, 6'd33);
		// Rounding exactly half way between two integers, and the finest slope.
		queue_request(1'b0, 1'b0, 16'd1000,  8'd0,   8'd1,   6'd1,  6'd2);
		queue_request(1'b0, 1'b1, 16'd900,   8'd255, 8'd0,   6'd1,  6'd63);
		// Steps either side of the upper clamp and a power of two in between.
		queue_request(1'b0, 1'b0, 16'd1024,  8'd100, 8'd100, 6'd0,  6'd1);
		queue_request(1'b1, 1'b1, 16'd1025,  8'd100, 8'd100, 6'd0,  6'd1);
		queue_request(1'b0, 1'b0, 16'd1023,  8'd100, 8'd100, 6'd0,  6'd1);
		queue_request(1'b1, 1'b0, 16'd256,   8'd100, 8'd100, 6'd0,  6'd1);
		// Steps around the lower clamps.
		queue_request(1'b0, 1'b0, 16'd3,     8'd100, 8'd100, 6'd0,  6'd1);
		queue_request(1'b0, 1'b1, 16'd3,     8'd100, 8'd100, 6'd0,  6'd1);
		queue_request(1'b0, 1'b0, 16'd2,     8'd100, 8'd100, 6'd0,  6'd1);
		queue_request(1'b1, 1'b1, 16'd8,     8'd100, 8'd100, 6'd0,  6'd1);
		queue_request(1'b0, 1'b0, 16'hFFFF,  8'd1,   8'd1,   6'd0,  6'd1);
		// Alternating bit patterns on every field.
		queue_request(1'b1, 1'b0, 16'hAAAA,  8'h55,  8'hAA,  6'h2A, 6'h15);
		queue_request(1'b0, 1'b1, 16'h5555,  8'hAA,  8'h55,  6'h15, 6'h2A);
		wait_for_drain();

		// Random part. Most requests lie inside their range; the rest cover a zero span,
		// an offset equal to the span and arbitrary pairs of span and offset.
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 84) begin
				span   = $urandom_range(1, 63);
				offset = $urandom_range(0, span - 1);
			end else if (pick < 90) begin
				span   = 0;
				offset = $urandom_range(0, 63);
			end else if (pick < 95) begin
				span   = $urandom_range(1, 63);
				offset = span;
			end else begin
				span   = $urandom_range(0, 63);
				offset = $urandom_range(0, 63);
			end
			// Scales are spread so that steps fall below, inside and above the clamps.
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				scale = 16'($urandom);
			end else if (pick < 75) begin
				scale = 16'($urandom_range(0, 2000));
			end else begin
				scale = 16'($urandom_range(0, 60));
			end
			queue_request(1'($urandom), 1'($urandom), scale, 8'($urandom), 8'($urandom),
				6'(offset), 6'(span));
			// Part way through, the sender stops until the pipeline has emptied.
			if (n == 700) begin
				wait_for_drain();
			end
		end
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
